FILE: rtl/lpfr_pkg.sv
package lpfr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = WORD_W;

    localparam logic [WORD_W-1:0] SYNC_WORD_RST = 16'hF00D;
    localparam logic [WORD_W-1:0] MAX_LEN_RST   = 16'd2048;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 1'd1;

    typedef enum logic [1:0] {
        PH_SYNC    = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CLOSED  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_BAD_SYNC = 2'd2,
        KIND_OVERSIZE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              end_of_packet;
        kind_t             result_kind;
    } result_t;

    // handshake between the parser and the result register
    typedef struct packed {
        logic    valid;
        result_t result;
    } res_beat_t;

endpackage

FILE: rtl/lpfr_if.sv
interface lpfr_byte_if import lpfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpfr_result_if import lpfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              end_of_packet;
    kind_t             result_kind;

    modport source (output valid, output payload_byte, output end_of_packet,
                    output result_kind, input ready);
    modport sink   (input valid, input payload_byte, input end_of_packet,
                    input result_kind, output ready);
endinterface

FILE: rtl/lpfr_in_stage.sv
module lpfr_in_stage import lpfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    lpfr_byte_if.sink         rx,
    input  logic              take,
    output logic              item_valid,
    output logic [BYTE_W-1:0] item_byte
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // refill in the same cycle the held beat is taken
    assign rx.ready   = !valid_reg || take;
    assign valid_next = rx.valid ? 1'b1 : (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.in_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

FILE: rtl/lpfr_parser.sv
module lpfr_parser import lpfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [BYTE_W-1:0] item_byte,
    input  logic [WORD_W-1:0] sync_word,
    input  logic [WORD_W-1:0] max_payload_len,
    input  logic              out_free,
    output logic              take,
    output res_beat_t         res
);

    phase_t            phase_reg, phase_next;
    logic              high_byte_next_reg, high_byte_next_next;
    logic [BYTE_W-1:0] low_byte_hold_reg, low_byte_hold_next;
    logic [WORD_W-1:0] bytes_remaining_reg, bytes_remaining_next;
    logic [WORD_W-1:0] word;
    logic              has_res;
    result_t           result;

    assign take = item_valid && out_free;
    assign word = {item_byte, low_byte_hold_reg};

    always_comb
    begin
        phase_next           = phase_reg;
        high_byte_next_next  = high_byte_next_reg;
        low_byte_hold_next   = low_byte_hold_reg;
        bytes_remaining_next = bytes_remaining_reg;
        has_res              = 1'b0;
        result.payload_byte  = '0;
        result.end_of_packet = 1'b0;
        result.result_kind   = KIND_DATA;

        unique case (phase_reg) inside
            PH_SYNC, PH_LENGTH:
            begin
                if (!high_byte_next_reg)
                begin
                    low_byte_hold_next  = item_byte;
                    high_byte_next_next = 1'b1;
                end
                else
                begin
                    high_byte_next_next = 1'b0;
                    low_byte_hold_next  = '0;
                    if (phase_reg == PH_SYNC)
                    begin
                        if (word != sync_word)
                        begin
                            phase_next         = PH_CLOSED;
                            has_res            = 1'b1;
                            result.result_kind = KIND_BAD_SYNC;
                        end
                        else
                        begin
                            phase_next = PH_LENGTH;
                        end
                    end
                    else if (word > max_payload_len)
                    begin
                        phase_next         = PH_CLOSED;
                        has_res            = 1'b1;
                        result.result_kind = KIND_OVERSIZE;
                    end
                    else if (word == '0)
                    begin
                        phase_next           = PH_SYNC;
                        has_res              = 1'b1;
                        result.end_of_packet = 1'b1;
                        result.result_kind   = KIND_EMPTY;
                    end
                    else
                    begin
                        bytes_remaining_next = word;
                        phase_next           = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (bytes_remaining_reg == '0)
                begin
                    // cannot be reached; recover to hunting for a sync word
                    phase_next          = PH_SYNC;
                    high_byte_next_next = 1'b0;
                end
                else
                begin
                    bytes_remaining_next = bytes_remaining_reg - WORD_W'(1);
                    has_res              = 1'b1;
                    result.payload_byte  = item_byte;
                    if (bytes_remaining_reg == WORD_W'(1))
                    begin
                        phase_next           = PH_SYNC;
                        high_byte_next_next  = 1'b0;
                        low_byte_hold_next   = '0;
                        result.end_of_packet = 1'b1;
                    end
                end
            end
            PH_CLOSED:
            begin
                // dropping everything until reset
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_SYNC;
            high_byte_next_reg  <= 1'b0;
            low_byte_hold_reg   <= '0;
            bytes_remaining_reg <= '0;
        end
        else if (take)
        begin
            phase_reg           <= phase_next;
            high_byte_next_reg  <= high_byte_next_next;
            low_byte_hold_reg   <= low_byte_hold_next;
            bytes_remaining_reg <= bytes_remaining_next;
        end
    end

    assign res.valid  = take && has_res;
    assign res.result = result;

    a_closed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CLOSED |=> phase_reg == PH_CLOSED)
        else $error("receiver left closed state");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> bytes_remaining_reg != '0)
        else $error("payload phase with nothing left");

    a_error_closes: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.result.result_kind == KIND_BAD_SYNC
                      || res.result.result_kind == KIND_OVERSIZE)
        |=> phase_reg == PH_CLOSED)
        else $error("error result without closing");

    a_header_parity: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD || phase_reg == PH_CLOSED) && take
        |=> phase_reg != PH_LENGTH || !high_byte_next_reg)
        else $error("length word started mid-byte");

endmodule

FILE: rtl/lpfr_out_stage.sv
module lpfr_out_stage import lpfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  res_beat_t   res,
    output logic        out_free,
    lpfr_result_if.source pkt
);

    logic    valid_reg;
    result_t result_reg;

    assign out_free = !valid_reg || pkt.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res.valid)
        begin
            result_reg <= res.result;
        end
    end

    assign pkt.valid         = valid_reg;
    assign pkt.payload_byte  = result_reg.payload_byte;
    assign pkt.end_of_packet = result_reg.end_of_packet;
    assign pkt.result_kind   = result_reg.result_kind;

endmodule

FILE: rtl/length_prefixed_frame_receiver_core.sv
// Length-prefixed frame receiver.
// rx carries the link byte stream, one byte per beat. Each frame is a 16-bit
// little-endian sync word, a 16-bit little-endian length, then the payload.
// pkt carries one result per payload byte (end_of_packet on the last one),
// an empty-packet result for a zero length, or an error result for a bad
// sync word or an oversize length; after an error all bytes are dropped
// until reset. Header bytes that pass give no result.
// Throughput: one byte per clock while pkt is not stalled, set by the single
// parse stage between the input register and the result register. A byte
// taken on rx is held in the input register, parsed, and its result is
// registered in the result register before it is offered on pkt.
// When pkt stalls, the result register holds and the input register takes
// one more byte only if it is empty; rx.ready then drops until pkt frees up.
// Reset clears both stages, returns to hunting for a sync word and restores
// sync_word to 0xF00D and max_payload_len to 2048. Registers are written via
// cfg_we/cfg_index/cfg_wdata and should only change while the block is idle.
module length_prefixed_frame_receiver_core import lpfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    lpfr_byte_if.sink            rx,
    lpfr_result_if.source        pkt,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [WORD_W-1:0] sync_word_reg;
    logic [WORD_W-1:0] max_payload_len_reg;
    logic              take;
    logic              out_free;
    logic              item_valid;
    logic [BYTE_W-1:0] item_byte;
    res_beat_t         res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg       <= SYNC_WORD_RST;
            max_payload_len_reg <= MAX_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_WORD: sync_word_reg       <= cfg_wdata[WORD_W-1:0];
                CFG_MAX_LEN:   max_payload_len_reg <= cfg_wdata[WORD_W-1:0];
                default:       sync_word_reg       <= sync_word_reg;
            endcase
        end
    end

    lpfr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .take       (take),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    lpfr_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_byte       (item_byte),
        .sync_word       (sync_word_reg),
        .max_payload_len (max_payload_len_reg),
        .out_free        (out_free),
        .take            (take),
        .res             (res)
    );

    lpfr_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .out_free (out_free),
        .pkt      (pkt)
    );

endmodule
